/* rtl/cpsl_pkg.sv */
package cpsl_pkg;

    // APB register map
    localparam int APB_ADDR_W = 5;
    localparam int REG_IDX_W  = 3;

    localparam logic [REG_IDX_W-1:0] REG_CAP_MIN_VOLTAGE        = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_CHARGE_CURRENT_TARGET  = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_DRIVE_MAX              = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_TARGET_POWER_MAX       = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_LIMIT_MARGIN           = 3'd4;
    localparam logic [REG_IDX_W-1:0] REG_LOW_ENERGY_THRESHOLD   = 3'd5;
    localparam logic [REG_IDX_W-1:0] REG_BATTERY_ABSENT_VOLTAGE = 3'd6;

    typedef struct packed {
        logic [15:0] cap_min_voltage;
        logic [14:0] charge_current_target;
        logic [15:0] drive_max;
        logic [15:0] target_power_max;
        logic [15:0] limit_margin;
        logic [15:0] low_energy_threshold;
        logic [15:0] battery_absent_voltage;
    } cfg_t;

    localparam cfg_t CFG_RESET = '{
        cap_min_voltage:        16'd800,
        charge_current_target:  15'd9000,
        drive_max:              16'd4120,
        target_power_max:       16'd12000,
        limit_margin:           16'd900,
        low_energy_threshold:   16'd8,
        battery_absent_voltage: 16'd100
    };

    // Q2.16 gains, truncated toward zero
    localparam logic signed [17:0] GAIN_P01  = 18'sd655;
    localparam logic signed [17:0] GAIN_P07  = 18'sd4587;
    localparam logic signed [17:0] GAIN_P7   = 18'sd45875;
    // floor(x/100) = (x * RECIP_100) >> 23 for any 16-bit x
    localparam logic signed [17:0] RECIP_100 = 18'sd83887;

    // Step clamps in Q.16
    localparam int STEP_LO = -40 * 65536;
    localparam int STEP_HI = 8 * 65536;
    localparam int ERR_LO  = -7 * 65536;
    localparam int ERR_HI  = 3 * 65536;

    localparam logic signed [10:0] PENALTY_MIN = -11'sd1000;
    localparam logic [15:0] DRIVE_LOW_ENERGY = 16'd500;
    localparam logic [15:0] DRIVE_NO_BATTERY = 16'd1;

    // Microcode fields
    typedef logic [3:0] step_t;

    typedef enum logic [2:0] {
        A_ENERGY, A_INNER, A_CUR_ERR, A_TARGET, A_PCAP, A_DIFF, A_PWR_ERR, A_PENALTY
    } a_sel_t;

    typedef enum logic [2:0] {
        B_P01, B_P07, B_P7, B_RECIP, B_DIFF
    } b_sel_t;

    typedef enum logic [2:0] {
        ACT_NONE, ACT_INNER, ACT_TARGET, ACT_TD100, ACT_DIFF, ACT_PENALTY, ACT_ERR, ACT_COMMIT
    } act_t;

    typedef enum logic [1:0] {
        COND_NEXT, COND_BELOW, COND_JUMP, COND_HOLD
    } cond_t;

    typedef struct packed {
        a_sel_t a_sel;
        b_sel_t b_sel;
        logic   prod_en;
        act_t   act;
        cond_t  cond;
        step_t  jump;
        logic   last;
    } ctrl_t;

    typedef struct packed {
        logic below;
        logic out_free;
    } flags_t;

    localparam ctrl_t CTRL_IDLE = '{
        a_sel:   A_ENERGY,
        b_sel:   B_P01,
        prod_en: 1'b0,
        act:     ACT_NONE,
        cond:    COND_NEXT,
        jump:    4'd0,
        last:    1'b1
    };

endpackage

/* rtl/cpsl_regs.sv */
module cpsl_regs
    import cpsl_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [31:0]           pwdata,
    output logic [31:0]           prdata,
    output cfg_t                  cfg
);

    cfg_t                 cfg_reg;
    cfg_t                 cfg_next;
    logic [REG_IDX_W-1:0] idx;
    logic                 wr_en;

    assign idx   = paddr[APB_ADDR_W-1:2];
    assign wr_en = psel && penable && pwrite;
    assign cfg   = cfg_reg;

    // Decode the write
    always_comb begin
        cfg_next = cfg_reg;
        if (wr_en) begin
            unique case (idx)
                REG_CAP_MIN_VOLTAGE:        cfg_next.cap_min_voltage        = pwdata[15:0];
                REG_CHARGE_CURRENT_TARGET:  cfg_next.charge_current_target  = pwdata[14:0];
                REG_DRIVE_MAX:              cfg_next.drive_max              = pwdata[15:0];
                REG_TARGET_POWER_MAX:       cfg_next.target_power_max       = pwdata[15:0];
                REG_LIMIT_MARGIN:           cfg_next.limit_margin           = pwdata[15:0];
                REG_LOW_ENERGY_THRESHOLD:   cfg_next.low_energy_threshold   = pwdata[15:0];
                REG_BATTERY_ABSENT_VOLTAGE: cfg_next.battery_absent_voltage = pwdata[15:0];
                default:                    cfg_next = cfg_reg;
            endcase
        end
    end

    // Read mux
    always_comb begin
        unique case (idx)
            REG_CAP_MIN_VOLTAGE:        prdata = {16'h0, cfg_reg.cap_min_voltage};
            REG_CHARGE_CURRENT_TARGET:  prdata = {17'h0, cfg_reg.charge_current_target};
            REG_DRIVE_MAX:              prdata = {16'h0, cfg_reg.drive_max};
            REG_TARGET_POWER_MAX:       prdata = {16'h0, cfg_reg.target_power_max};
            REG_LIMIT_MARGIN:           prdata = {16'h0, cfg_reg.limit_margin};
            REG_LOW_ENERGY_THRESHOLD:   prdata = {16'h0, cfg_reg.low_energy_threshold};
            REG_BATTERY_ABSENT_VOLTAGE: prdata = {16'h0, cfg_reg.battery_absent_voltage};
            default:                    prdata = 32'h0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= CFG_RESET;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

/* rtl/cpsl_seq.sv */
module cpsl_seq
    import cpsl_pkg::*;
(
    input  logic   aclk,
    input  logic   aresetn,
    input  logic   start,
    input  flags_t flags,
    output ctrl_t  ctl,
    output logic   busy
);

    localparam step_t STEP_ERR     = 4'd9;
    localparam step_t STEP_CUR_ERR = 4'd11;

    // Control store: one word per step
    function automatic ctrl_t ucode_rom(input step_t s);
        ctrl_t w;
        w = CTRL_IDLE;
        case (s)
            // energy * 0.01
            4'd0:  w = '{A_ENERGY,  B_P01,   1'b1, ACT_NONE,    COND_NEXT,  4'd0, 1'b0};
            // inner = (limit - battery) + energy * 0.01
            4'd1:  w = '{A_ENERGY,  B_P01,   1'b0, ACT_INNER,   COND_NEXT,  4'd0, 1'b0};
            // inner * 0.01
            4'd2:  w = '{A_INNER,   B_P01,   1'b1, ACT_NONE,    COND_NEXT,  4'd0, 1'b0};
            // accumulate and clamp target
            4'd3:  w = '{A_INNER,   B_P01,   1'b0, ACT_TARGET,  COND_NEXT,  4'd0, 1'b0};
            // target / 100, branch on the knee
            4'd4:  w = '{A_TARGET,  B_RECIP, 1'b1, ACT_NONE,    COND_BELOW, STEP_CUR_ERR, 1'b0};
            // power / 100
            4'd5:  w = '{A_PCAP,    B_RECIP, 1'b1, ACT_TD100,   COND_NEXT,  4'd0, 1'b0};
            4'd6:  w = '{A_PCAP,    B_RECIP, 1'b0, ACT_DIFF,    COND_NEXT,  4'd0, 1'b0};
            // square the difference
            4'd7:  w = '{A_DIFF,    B_DIFF,  1'b1, ACT_NONE,    COND_NEXT,  4'd0, 1'b0};
            // penalty, power error * 0.7
            4'd8:  w = '{A_PWR_ERR, B_P7,    1'b1, ACT_PENALTY, COND_NEXT,  4'd0, 1'b0};
            // clamp error, penalty * 0.07
            4'd9:  w = '{A_PENALTY, B_P07,   1'b1, ACT_ERR,     COND_NEXT,  4'd0, 1'b0};
            // accumulate drive and commit once the output slot is free
            4'd10: w = '{A_PENALTY, B_P07,   1'b0, ACT_COMMIT,  COND_HOLD,  4'd0, 1'b1};
            // below the knee: current error * 0.07
            4'd11: w = '{A_CUR_ERR, B_P07,   1'b1, ACT_NONE,    COND_JUMP,  STEP_ERR, 1'b0};
            default: w = CTRL_IDLE;
        endcase
        return w;
    endfunction

    step_t step_reg;
    step_t step_next;
    logic  busy_reg;
    logic  busy_next;
    ctrl_t word;
    logic  fire;

    assign word = ucode_rom(step_reg);
    assign fire = busy_reg && !(word.cond == COND_HOLD && !flags.out_free);
    assign busy = busy_reg;

    // Drop datapath actions while idle or holding
    always_comb begin
        ctl = word;
        if (!fire) begin
            ctl.act     = ACT_NONE;
            ctl.prod_en = 1'b0;
        end
    end

    // Advance the step counter
    always_comb begin
        step_next = step_reg;
        busy_next = busy_reg;
        if (start) begin
            step_next = '0;
            busy_next = 1'b1;
        end else if (fire) begin
            if (word.last) begin
                busy_next = 1'b0;
            end else begin
                unique case (word.cond)
                    COND_NEXT:  step_next = step_reg + 4'd1;
                    COND_BELOW: step_next = flags.below ? word.jump : step_reg + 4'd1;
                    COND_JUMP:  step_next = word.jump;
                    COND_HOLD:  step_next = step_reg + 4'd1;
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            step_reg <= '0;
            busy_reg <= 1'b0;
        end else begin
            step_reg <= step_next;
            busy_reg <= busy_next;
        end
    end

endmodule

/* rtl/cpsl_dp.sv */
module cpsl_dp
    import cpsl_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  cfg_t        cfg,
    input  ctrl_t       ctl,
    input  logic        load,
    input  logic [15:0] s_cap_voltage,
    input  logic [14:0] s_cap_current,
    input  logic [15:0] s_cap_power,
    input  logic [15:0] s_bat_power,
    input  logic [15:0] s_battery_voltage,
    input  logic [15:0] s_power_limit,
    input  logic [15:0] s_energy_left,
    input  logic        s_cap_off_request,
    output flags_t      flags,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [14:0] m_pwm_compare,
    output logic [15:0] m_drive_level,
    output logic [15:0] m_target_power,
    output logic        m_cap_path_on,
    output logic        m_path_changed
);

    localparam logic signed [36:0] STEP_MIN = 37'(STEP_LO);
    localparam logic signed [36:0] STEP_MAX = 37'(STEP_HI);
    localparam logic signed [52:0] ERR_MIN  = 53'(ERR_LO);
    localparam logic signed [52:0] ERR_MAX  = 53'(ERR_HI);

    // Captured transaction
    logic [15:0] v_cap_reg;
    logic [14:0] i_cap_reg;
    logic [15:0] p_cap_reg;
    logic [15:0] p_bat_reg;
    logic [15:0] v_bat_reg;
    logic [15:0] limit_reg;
    logic [15:0] energy_reg;
    logic        off_reg;

    // Scratch
    logic signed [52:0] prod_reg;
    logic signed [34:0] inner_reg;
    logic [15:0]        tar_new_reg;
    logic [9:0]         td100_reg;
    logic signed [10:0] diff_reg;
    logic signed [19:0] err_reg;

    // Loop state
    logic [15:0]        target_power_reg;
    logic [15:0]        drive_reg;
    logic signed [10:0] penalty_reg;
    logic               path_on_reg;
    logic               changed_reg;
    logic               m_valid_reg;

    logic signed [34:0] mul_a;
    logic signed [17:0] mul_b;
    logic signed [52:0] mul_p;
    logic signed [15:0] cur_err;
    logic signed [16:0] pwr_err;
    logic signed [16:0] lp_diff;
    logic signed [34:0] inner_next;
    logic [15:0]        ceiling;
    logic signed [52:0] prod_round;
    logic signed [36:0] step_raw;
    logic signed [22:0] step_c;
    logic signed [33:0] tar_sum;
    logic [16:0]        tar_acc;
    logic [15:0]        tar_ceil;
    logic [15:0]        tar_cand;
    logic [19:0]        vcap_p1;
    logic [19:0]        vcap9;
    logic [9:0]         quot100;
    logic signed [10:0] penalty_next;
    logic signed [19:0] err_next;
    logic signed [33:0] drive_sum;
    logic [16:0]        drive_acc;
    logic [15:0]        drive_clamp;
    logic [15:0]        drive_final;
    logic [15:0]        target_final;
    logic               path_new;
    logic               commit;

    assign commit = (ctl.act == ACT_COMMIT);

    // Operand selection for the shared multiplier
    assign cur_err = $signed({1'b0, cfg.charge_current_target}) - $signed({1'b0, i_cap_reg});
    assign pwr_err = $signed({1'b0, tar_new_reg}) - $signed({1'b0, p_cap_reg});

    always_comb begin
        unique case (ctl.a_sel)
            A_ENERGY:  mul_a = $signed({19'h0, energy_reg});
            A_INNER:   mul_a = inner_reg;
            A_CUR_ERR: mul_a = 35'(cur_err);
            A_TARGET:  mul_a = $signed({19'h0, tar_new_reg});
            A_PCAP:    mul_a = $signed({19'h0, p_cap_reg});
            A_DIFF:    mul_a = 35'(diff_reg);
            A_PWR_ERR: mul_a = 35'(pwr_err);
            A_PENALTY: mul_a = 35'(penalty_reg);
            default:   mul_a = '0;
        endcase
    end

    always_comb begin
        unique case (ctl.b_sel)
            B_P01:   mul_b = GAIN_P01;
            B_P07:   mul_b = GAIN_P07;
            B_P7:    mul_b = GAIN_P7;
            B_RECIP: mul_b = RECIP_100;
            B_DIFF:  mul_b = 18'(diff_reg);
            default: mul_b = '0;
        endcase
    end

    assign mul_p = mul_a * mul_b;

    // Inner term: (limit - battery power) in Q.16 plus the scaled energy
    assign lp_diff    = $signed({1'b0, limit_reg}) - $signed({1'b0, p_bat_reg});
    assign inner_next = {{2{lp_diff[16]}}, lp_diff, 16'h0000} + prod_reg[34:0];

    // Target ceiling saturates at zero
    assign ceiling = (cfg.limit_margin > limit_reg) ? 16'h0 : limit_reg - cfg.limit_margin;

    // Target step: rescale toward zero, clamp, accumulate, clamp
    assign prod_round = prod_reg + $signed({37'h0, {16{prod_reg[52]}}});
    assign step_raw   = prod_round[52:16];

    always_comb begin
        if (step_raw < STEP_MIN) begin
            step_c = STEP_MIN[22:0];
        end else if (step_raw > STEP_MAX) begin
            step_c = STEP_MAX[22:0];
        end else begin
            step_c = step_raw[22:0];
        end
    end

    assign tar_sum  = $signed({2'b00, target_power_reg, 16'h0000}) + 34'(step_c);
    assign tar_acc  = tar_sum[33] ? 17'h0 : tar_sum[32:16];
    assign tar_ceil = (tar_acc > {1'b0, ceiling}) ? ceiling : tar_acc[15:0];
    assign tar_cand = (tar_ceil > cfg.target_power_max) ? cfg.target_power_max : tar_ceil;

    // Knee test: v < floor(t/9) is 9*(v+1) <= t
    assign vcap_p1     = {4'h0, v_cap_reg} + 20'd1;
    assign vcap9       = (vcap_p1 << 3) + vcap_p1;
    assign flags.below = (vcap9 <= {4'h0, tar_new_reg});
    assign flags.out_free = !m_valid_reg || m_ready;

    assign quot100 = prod_reg[32:23];

    // Squared overshoot penalty, clamped to the floor
    always_comb begin
        if (tar_new_reg < p_cap_reg) begin
            if (prod_reg > 53'sd1000) begin
                penalty_next = PENALTY_MIN;
            end else begin
                penalty_next = -$signed({1'b0, prod_reg[9:0]});
            end
        end else begin
            penalty_next = '0;
        end
    end

    always_comb begin
        if (prod_reg < ERR_MIN) begin
            err_next = ERR_MIN[19:0];
        end else if (prod_reg > ERR_MAX) begin
            err_next = ERR_MAX[19:0];
        end else begin
            err_next = prod_reg[19:0];
        end
    end

    // Drive accumulation, clamp, then overrides
    assign drive_sum   = $signed({2'b00, drive_reg, 16'h0000}) + 34'(err_reg)
                         + $signed(prod_reg[33:0]);
    assign drive_acc   = drive_sum[33] ? 17'h0 : drive_sum[32:16];
    assign drive_clamp = (drive_acc > {1'b0, cfg.drive_max}) ? cfg.drive_max : drive_acc[15:0];

    always_comb begin
        drive_final  = drive_clamp;
        target_final = tar_new_reg;
        if (energy_reg < cfg.low_energy_threshold) begin
            drive_final = DRIVE_LOW_ENERGY;
        end
        if (v_bat_reg < cfg.battery_absent_voltage) begin
            drive_final  = DRIVE_NO_BATTERY;
            target_final = ceiling;
        end
    end

    assign path_new = !off_reg && (v_cap_reg >= cfg.cap_min_voltage);

    // Capture the transaction and hold scratch values
    always_ff @(posedge aclk) begin
        if (load) begin
            v_cap_reg  <= s_cap_voltage;
            i_cap_reg  <= s_cap_current;
            p_cap_reg  <= s_cap_power;
            p_bat_reg  <= s_bat_power;
            v_bat_reg  <= s_battery_voltage;
            limit_reg  <= s_power_limit;
            energy_reg <= s_energy_left;
            off_reg    <= s_cap_off_request;
        end
        if (ctl.prod_en) begin
            prod_reg <= mul_p;
        end
        case (ctl.act)
            ACT_INNER:  inner_reg   <= inner_next;
            ACT_TARGET: tar_new_reg <= tar_cand;
            ACT_TD100:  td100_reg   <= quot100;
            ACT_DIFF:   diff_reg    <= $signed({1'b0, td100_reg}) - $signed({1'b0, quot100});
            ACT_ERR:    err_reg     <= err_next;
            default: ;
        endcase
    end

    // Loop state and the result slot
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            target_power_reg <= '0;
            drive_reg        <= '0;
            penalty_reg      <= '0;
            path_on_reg      <= 1'b0;
            changed_reg      <= 1'b0;
            m_valid_reg      <= 1'b0;
        end else begin
            if (ctl.act == ACT_PENALTY) begin
                penalty_reg <= penalty_next;
            end
            if (commit) begin
                target_power_reg <= target_final;
                drive_reg        <= drive_final;
                path_on_reg      <= path_new;
                changed_reg      <= (path_new != path_on_reg);
                m_valid_reg      <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg      <= 1'b0;
            end
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_pwm_compare  = drive_reg[15:1];
    assign m_drive_level  = drive_reg;
    assign m_target_power = target_power_reg;
    assign m_cap_path_on  = path_on_reg;
    assign m_path_changed = changed_reg;

`ifndef ASSERT_OFF
    a_penalty_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (penalty_reg <= 11'sd0) && (penalty_reg >= PENALTY_MIN))
        else $error("overshoot penalty out of range");

    a_drive_clamp: assert property (@(posedge aclk) disable iff (!aresetn)
        commit && (v_bat_reg >= cfg.battery_absent_voltage)
        && (energy_reg >= cfg.low_energy_threshold)
        |=> drive_reg <= $past(cfg.drive_max))
        else $error("drive level above its clamp");

    a_target_ceiling: assert property (@(posedge aclk) disable iff (!aresetn)
        commit |=> target_power_reg <= $past(ceiling))
        else $error("target power above the limit ceiling");
`endif

endmodule

/* rtl/capacitor_power_sharing_loop.sv */
// Capacitor power sharing loop, one control tick per transaction.
//
// Input channel (s_*): one tick of measurements and the cap-off request.
// Result channel (m_*): PWM compare, drive level, target power, selected
// path and a path-change flag for that tick. Both are valid/ready.
// The user must write the registers through the APB port only while the block is idle; the block does not enforce this.
//
// Each tick runs a microcoded program over one shared 35x18 multiplier;
// below the voltage knee it skips the square penalty path taken above it.
// s_ready is low during reset and while a tick runs, so a new tick is
// accepted only once the previous program has finished.
// The result is held in the output register until taken; a new tick may
// be accepted meanwhile, and its final step waits while m_valid is high
// and m_ready is low.
// Reset restores the register defaults, clears target, drive and penalty,
// selects the battery path and drops any pending result.
module capacitor_power_sharing_loop
    import cpsl_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,

    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [31:0]           pwdata,
    output logic [31:0]           prdata,
    output logic                  pready,

    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic [15:0]           s_cap_voltage,
    input  logic [14:0]           s_cap_current,
    input  logic [15:0]           s_cap_power,
    input  logic [15:0]           s_bat_power,
    input  logic [15:0]           s_battery_voltage,
    input  logic [15:0]           s_power_limit,
    input  logic [15:0]           s_energy_left,
    input  logic                  s_cap_off_request,

    output logic                  m_valid,
    input  logic                  m_ready,
    output logic [14:0]           m_pwm_compare,
    output logic [15:0]           m_drive_level,
    output logic [15:0]           m_target_power,
    output logic                  m_cap_path_on,
    output logic                  m_path_changed
);

    cfg_t   cfg;
    ctrl_t  ctl;
    flags_t flags;
    logic   busy;
    logic   accept;

    assign pready  = 1'b1;
    assign s_ready = !busy && aresetn;
    assign accept  = s_valid && s_ready;

    // Configuration registers
    cpsl_regs u_regs (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .cfg     (cfg)
    );

    // Program sequencer
    cpsl_seq u_seq (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (accept),
        .flags   (flags),
        .ctl     (ctl),
        .busy    (busy)
    );

    // Datapath and loop state
    cpsl_dp u_dp (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .cfg               (cfg),
        .ctl               (ctl),
        .load              (accept),
        .s_cap_voltage     (s_cap_voltage),
        .s_cap_current     (s_cap_current),
        .s_cap_power       (s_cap_power),
        .s_bat_power       (s_bat_power),
        .s_battery_voltage (s_battery_voltage),
        .s_power_limit     (s_power_limit),
        .s_energy_left     (s_energy_left),
        .s_cap_off_request (s_cap_off_request),
        .flags             (flags),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_pwm_compare     (m_pwm_compare),
        .m_drive_level     (m_drive_level),
        .m_target_power    (m_target_power),
        .m_cap_path_on     (m_cap_path_on),
        .m_path_changed    (m_path_changed)
    );

endmodule
